@@ hdl/assert_macros.svh @@
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition that must hold in the cycle after a trigger
`define CHK_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

@@ hdl/rilex_pkg.sv @@
// package with types and constants for the radix integer lexer
package rilex_pkg;

    // number base codes
    typedef enum logic [1:0] {
        RADIX_OCT   = 2'd0,
        RADIX_DEC   = 2'd1,
        RADIX_HEX   = 2'd2,
        RADIX_UNSET = 2'd3
    } t_radix;

    // parse phase of the number in progress
    typedef enum logic [1:0] {
        PH_SIGN       = 2'd0,
        PH_PREFIX     = 2'd1,
        PH_AFTER_ZERO = 2'd2,
        PH_DIGITS     = 2'd3
    } t_phase;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 8;
    localparam int OUT_W   = VALUE_W + CHAR_W;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_7     = 8'h37;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

endpackage

@@ hdl/radix_integer_lexer_top.sv @@
// Radix integer lexer: ascii characters in, one signed 64-bit value per number out.
// A result is registered after the item that ends the number passes the input register.
// Throughput: one item per cycle unless a result waits for the output, with the
// accumulator update (shift-add of one digit) ahead of the number state register.
// Reset (synchronous, active low) empties both registers, clears the number in
// progress and sets the radix to decimal.
`include "assert_macros.svh"

module radix_integer_lexer_top
    import rilex_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: radix_mode
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    // input items
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [CHAR_W-1:0]   s_axis_tdata,   // [7:0] char_in
    input  logic                s_axis_tuser,   // [0] end_of_text
    // result items
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OUT_W-1:0]    m_axis_tdata,   // [63:0] value, [71:64] stop_char
    output logic                m_axis_tuser    // [0] ended_by_marker
);

    // registers
    logic                r_in_valid;
    logic [CHAR_W-1:0]   r_in_char;
    logic                r_in_eot;
    t_radix              r_radix;
    t_phase              r_phase, n_phase;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    logic                r_neg, n_neg;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [CHAR_W-1:0]   r_out_stop, n_out_stop;
    logic                r_out_marker;

    // combinational
    t_radix              w_radix;
    logic                w_is_digit;
    logic [3:0]          w_digit;
    logic                w_try_digit;
    logic                w_set_neg;
    logic                w_emit;
    logic                w_out_free;
    logic                w_advance;
    logic [VALUE_W-1:0]  w_acc_digit;

    // unset radix behaves as decimal
    assign w_radix = (r_radix == RADIX_UNSET) ? RADIX_DEC : r_radix;

    // digit decode for the current radix
    always_comb begin
        w_is_digit = 1'b0;
        w_digit    = 4'd0;
        case (w_radix)
            RADIX_OCT: begin
                if (r_in_char inside {[CH_0:CH_7]}) begin
                    w_is_digit = 1'b1;
                    w_digit    = 4'(r_in_char - CH_0);
                end
            end
            RADIX_HEX: begin
                if (r_in_char inside {[CH_0:CH_9]}) begin
                    w_is_digit = 1'b1;
                    w_digit    = 4'(r_in_char - CH_0);
                end else if (r_in_char inside {[CH_LA:CH_LF]}) begin
                    w_is_digit = 1'b1;
                    w_digit    = 4'(r_in_char - CH_LA + LETTER_BASE);
                end else if (r_in_char inside {[CH_UA:CH_UF]}) begin
                    w_is_digit = 1'b1;
                    w_digit    = 4'(r_in_char - CH_UA + LETTER_BASE);
                end
            end
            default: begin
                if (r_in_char inside {[CH_0:CH_9]}) begin
                    w_is_digit = 1'b1;
                    w_digit    = 4'(r_in_char - CH_0);
                end
            end
        endcase
    end

    // accumulator with one more digit
    always_comb begin
        case (w_radix)
            RADIX_OCT: w_acc_digit = (r_acc << 3) + VALUE_W'(w_digit);
            RADIX_HEX: w_acc_digit = (r_acc << 4) + VALUE_W'(w_digit);
            default:   w_acc_digit = (r_acc << 3) + (r_acc << 1) + VALUE_W'(w_digit);
        endcase
    end

    // next phase
    always_comb begin
        n_phase     = r_phase;
        w_try_digit = 1'b0;
        w_set_neg   = 1'b0;
        case (r_phase)
            PH_SIGN: begin
                if (r_in_char == CH_MINUS) begin
                    w_set_neg = 1'b1;
                    n_phase   = PH_PREFIX;
                end else if (r_in_char == CH_PLUS) begin
                    n_phase = PH_PREFIX;
                end else if (w_radix == RADIX_HEX && r_in_char == CH_0) begin
                    n_phase = PH_AFTER_ZERO;
                end else begin
                    w_try_digit = 1'b1;
                end
            end
            PH_PREFIX: begin
                if (w_radix == RADIX_HEX && r_in_char == CH_0) begin
                    n_phase = PH_AFTER_ZERO;
                end else begin
                    w_try_digit = 1'b1;
                end
            end
            PH_AFTER_ZERO: begin
                if (w_radix == RADIX_HEX && (r_in_char == CH_LX || r_in_char == CH_UX)) begin
                    n_phase = PH_DIGITS;
                end else begin
                    w_try_digit = 1'b1;
                end
            end
            default: begin
                w_try_digit = 1'b1;
            end
        endcase
        if (w_try_digit && w_is_digit) begin
            n_phase = PH_DIGITS;
        end
        if (r_in_eot || (w_try_digit && !w_is_digit)) begin
            n_phase = PH_SIGN;
        end
    end

    // number ends on the marker or on a non-digit
    assign w_emit = r_in_eot || (w_try_digit && !w_is_digit);

    // accumulator, sign and result fields
    always_comb begin
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_out_value = r_neg ? (VALUE_W'(0) - r_acc) : r_acc;
        n_out_stop  = r_in_eot ? CHAR_W'(0) : r_in_char;
        if (w_emit) begin
            n_acc = '0;
            n_neg = 1'b0;
        end else begin
            if (w_set_neg) begin
                n_neg = 1'b1;
            end
            if (w_try_digit) begin
                n_acc = w_acc_digit;
            end
        end
    end

    // handshake
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && (!w_emit || w_out_free);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_eot  <= s_axis_tuser;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_DEC;
        end else if (i_cfg_wr_en) begin
            r_radix <= t_radix'(i_cfg_wr_data);
        end
    end

    // number state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIGN;
            r_acc   <= '0;
            r_neg   <= 1'b0;
        end else if (w_advance) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_emit) begin
            r_out_value  <= n_out_value;
            r_out_stop   <= n_out_stop;
            r_out_marker <= r_in_eot;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_stop, r_out_value};
    assign m_axis_tuser  = r_out_marker;

    // checks
    `CHK_NEXT(a_clear_after_emit, w_advance && w_emit,
        r_phase == PH_SIGN && r_acc == '0 && !r_neg,
        "number state not cleared after a result")
    `CHK_ALWAYS(a_marker_stop_zero, m_axis_tvalid && m_axis_tuser |->
        m_axis_tdata[OUT_W-1:VALUE_W] == '0,
        "marker result carries a stop character")
    `CHK_ALWAYS(a_stall_only_on_full, !s_axis_tready |-> r_in_valid && r_out_valid,
        "input stalled without a pending result")

endmodule
